// ----- sv/assert_macros.svh -----
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define SSTOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication check built on the macro above.
`define SSTOK_ASSERT_IMP(lbl, ante, cons, msg) \
  `SSTOK_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- sv/sstok_pkg.sv -----
// Package with types, constants and helper functions of the source tokenizer.
`default_nettype none
package sstok_pkg;

  localparam int OFFSET_BITS_DEF = 20;
  localparam int LINE_BITS_DEF   = 16;
  localparam int MAX_KEYWORD_LEN = 8;
  localparam int QUEUE_DEPTH     = 4;
  localparam int MAX_RES         = 3;
  localparam int CNT_W           = 2;
  localparam int RES_FIX_W       = 12;
  localparam int NUM_KEYWORDS    = 18;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [4:0] KIND_DOT     = 5'd5;
  localparam logic [4:0] KIND_SLASH   = 5'd9;
  localparam logic [4:0] KIND_BANG    = 5'd11;
  localparam logic [4:0] KIND_BANG_EQ = 5'd12;
  localparam logic [4:0] KIND_STRING  = 5'd19;
  localparam logic [4:0] KIND_NUMBER  = 5'd20;
  localparam logic [4:0] KIND_KEYWORD = 5'd21;
  localparam logic [4:0] KIND_IDENT   = 5'd22;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CHAR     = 2'd1;
  localparam logic [1:0] ERR_UNTERM   = 2'd2;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_OPER, MODE_SLASH, MODE_COMMENT, MODE_STRING,
    MODE_INT, MODE_DOT, MODE_FRAC, MODE_WORD
  } mode_e;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } kw_t;

  typedef struct packed {
    logic       full;
    logic       empty;
  } fifo_stat_t;

  localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
    64'("and"), 64'("class"), 64'("else"), 64'("false"), 64'("true"),
    64'("for"), 64'("fun"), 64'("if"), 64'("nil"), 64'("or"),
    64'("print"), 64'("return"), 64'("super"), 64'("this"), 64'("var"),
    64'("while"), 64'("break"), 64'("continue")
  };
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd3, 4'd5, 4'd4, 4'd5, 4'd4, 4'd3, 4'd3, 4'd2, 4'd3, 4'd2,
    4'd5, 4'd6, 4'd5, 4'd4, 4'd3, 4'd5, 4'd5, 4'd8
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == 8'h5F);
  endfunction

  // Keyword match; all entries compare in parallel.
  function automatic kw_t kw_lookup(input logic [63:0] wb, input logic [3:0] wl);
    kw_t r;
    r = '0;
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      if (!r.hit && wl == KW_LEN[i] && wb == KW_TEXT[i]) begin
        r.hit = 1'b1;
        r.idx = 5'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/sstok_front.sv -----
// Scanner front end: classifies each byte and builds the batch of results it causes.
`default_nettype none
module sstok_front import sstok_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       eos_i,
  output logic            push_o,
  output logic [CNT_W+MAX_RES*(RES_FIX_W+2*OFFSET_BITS+LINE_BITS)-1:0] entry_o
);
  `include "assert_macros.svh"

  localparam int OB    = OFFSET_BITS;
  localparam int LB    = LINE_BITS;
  localparam int RES_W = RES_FIX_W + 2 * OB + LB;
  localparam int NCAND = 5;

  typedef struct packed {
    logic          v;
    logic [4:0]    kind;
    logic [4:0]    kw;
    logic [OB-1:0] s;
    logic [OB-1:0] e;
    logic [1:0]    err;
  } cand_t;

  typedef struct packed {
    cand_t a;
    cand_t b;
  } pair_t;

  mode_e         mode_q, mode_d;
  logic [1:0]    op_q, op_d;
  logic [OB-1:0] pos_q, pos_d, ts_q, ts_d, prev_q, prev_d, ne_q, ne_d;
  logic [LB-1:0] line_q, line_d, line_mid;
  logic [63:0]   wb_q, wb_d;
  logic [3:0]    wl_q, wl_d;

  cand_t         cand [NCAND];
  logic [LB-1:0] cline [NCAND];
  logic [RES_W-1:0] slot [MAX_RES];
  logic [1:0]    cnt;

  function automatic pair_t flush_f(input mode_e m, input logic [1:0] op,
                                    input logic [OB-1:0] ts, input logic [OB-1:0] ne,
                                    input kw_t k, input logic [OB-1:0] last);
    pair_t p;
    p = '0;
    p.a.s = ts;
    p.a.e = last;
    case (m)
      MODE_OPER: begin
        p.a.v    = 1'b1;
        p.a.kind = KIND_BANG + {2'b00, op, 1'b0};
      end
      MODE_SLASH: begin
        p.a.v    = 1'b1;
        p.a.kind = KIND_SLASH;
      end
      MODE_STRING: begin
        p.a.v   = 1'b1;
        p.a.err = ERR_UNTERM;
      end
      MODE_INT, MODE_FRAC: begin
        p.a.v    = 1'b1;
        p.a.kind = KIND_NUMBER;
      end
      MODE_DOT: begin
        p.a.v    = 1'b1;
        p.a.kind = KIND_NUMBER;
        p.a.e    = ne;
        p.b.v    = 1'b1;
        p.b.kind = KIND_DOT;
        p.b.s    = last;
        p.b.e    = last;
      end
      MODE_WORD: begin
        p.a.v    = 1'b1;
        p.a.kind = k.hit ? KIND_KEYWORD : KIND_IDENT;
        p.a.kw   = k.hit ? k.idx : 5'd0;
      end
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [LB-1:0] line_inc(input logic [LB-1:0] l);
    return (l == {LB{1'b1}}) ? l : l + LB'(1);
  endfunction

  pair_t pre_p, fin_p;
  cand_t mid_c;

  always_comb begin
    logic do_fresh;
    logic do_pre;
    mode_d   = mode_q;
    op_d     = op_q;
    ts_d     = ts_q;
    ne_d     = ne_q;
    wb_d     = wb_q;
    wl_d     = wl_q;
    line_mid = line_q;
    mid_c    = '0;
    do_fresh = 1'b0;
    do_pre   = 1'b0;

    unique case (mode_q)
      MODE_IDLE: do_fresh = 1'b1;
      MODE_OPER: begin
        if (byte_i == CH_EQ) begin
          mid_c.v    = 1'b1;
          mid_c.kind = KIND_BANG_EQ + {2'b00, op_q, 1'b0};
          mid_c.s    = ts_q;
          mid_c.e    = pos_q;
          mode_d     = MODE_IDLE;
        end else begin
          do_pre   = 1'b1;
          do_fresh = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (byte_i == CH_SLASH) mode_d = MODE_COMMENT;
        else begin
          do_pre   = 1'b1;
          do_fresh = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (byte_i == CH_NL) begin
          line_mid = line_inc(line_q);
          mode_d   = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (byte_i == CH_QUOTE) begin
          mid_c.v    = 1'b1;
          mid_c.kind = KIND_STRING;
          mid_c.s    = ts_q;
          mid_c.e    = pos_q;
          mode_d     = MODE_IDLE;
        end else if (byte_i == CH_NL) begin
          line_mid = line_inc(line_q);
        end
      end
      MODE_INT: begin
        if (byte_i == CH_DOT) begin
          ne_d   = prev_q;
          mode_d = MODE_DOT;
        end else if (!is_digit(byte_i)) begin
          do_pre   = 1'b1;
          do_fresh = 1'b1;
        end
      end
      MODE_DOT: begin
        if (is_digit(byte_i)) mode_d = MODE_FRAC;
        else begin
          do_pre   = 1'b1;
          do_fresh = 1'b1;
        end
      end
      MODE_FRAC: begin
        if (!is_digit(byte_i)) begin
          do_pre   = 1'b1;
          do_fresh = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_alpha(byte_i) || is_digit(byte_i)) begin
          if (wl_q < 4'(MAX_KEYWORD_LEN)) begin
            wb_d = {wb_q[55:0], byte_i};
            wl_d = wl_q + 4'd1;
          end else begin
            wl_d = 4'(MAX_KEYWORD_LEN + 1);
          end
        end else begin
          do_pre   = 1'b1;
          do_fresh = 1'b1;
        end
      end
      default: do_fresh = 1'b1;
    endcase

    pre_p = do_pre ? flush_f(mode_q, op_q, ts_q, ne_q, kw_lookup(wb_q, wl_q), prev_q)
                   : pair_t'('0);

    if (do_fresh) begin
      mode_d = MODE_IDLE;
      ts_d   = pos_q;
      mid_c.s = pos_q;
      mid_c.e = pos_q;
      case (byte_i)
        8'h28: begin mid_c.v = 1'b1; mid_c.kind = 5'd0;  end
        8'h29: begin mid_c.v = 1'b1; mid_c.kind = 5'd1;  end
        8'h7B: begin mid_c.v = 1'b1; mid_c.kind = 5'd2;  end
        8'h7D: begin mid_c.v = 1'b1; mid_c.kind = 5'd3;  end
        8'h2C: begin mid_c.v = 1'b1; mid_c.kind = 5'd4;  end
        CH_DOT: begin mid_c.v = 1'b1; mid_c.kind = KIND_DOT; end
        8'h2D: begin mid_c.v = 1'b1; mid_c.kind = 5'd6;  end
        8'h2B: begin mid_c.v = 1'b1; mid_c.kind = 5'd7;  end
        8'h3B: begin mid_c.v = 1'b1; mid_c.kind = 5'd8;  end
        8'h2A: begin mid_c.v = 1'b1; mid_c.kind = 5'd10; end
        8'h21: begin op_d = 2'd0; mode_d = MODE_OPER; end
        CH_EQ: begin op_d = 2'd1; mode_d = MODE_OPER; end
        8'h3E: begin op_d = 2'd2; mode_d = MODE_OPER; end
        8'h3C: begin op_d = 2'd3; mode_d = MODE_OPER; end
        CH_SLASH: mode_d = MODE_SLASH;
        CH_SPACE, CH_CR, CH_TAB: mode_d = MODE_IDLE;
        CH_NL: line_mid = line_inc(line_q);
        CH_QUOTE: mode_d = MODE_STRING;
        default: begin
          if (is_digit(byte_i)) begin
            mode_d = MODE_INT;
          end else if (is_alpha(byte_i)) begin
            wb_d   = {56'd0, byte_i};
            wl_d   = 4'd1;
            mode_d = MODE_WORD;
          end else begin
            mid_c.v   = 1'b1;
            mid_c.err = ERR_CHAR;
          end
        end
      endcase
    end

    fin_p = eos_i ? flush_f(mode_d, op_d, ts_d, ne_d, kw_lookup(wb_d, wl_d), pos_q)
                  : pair_t'('0);

    line_d = line_mid;
    pos_d  = (pos_q == {OB{1'b1}}) ? pos_q : pos_q + OB'(1);
    prev_d = pos_q;
    if (eos_i) begin
      mode_d = MODE_IDLE;
      op_d   = 2'd0;
      pos_d  = '0;
      ts_d   = '0;
      line_d = LB'(1);
      wb_d   = '0;
      wl_d   = '0;
      prev_d = '0;
      ne_d   = '0;
    end
  end

  // Results before the final flush carry the line as it was; the flush sees any newline.
  always_comb begin
    cand[0]  = pre_p.a;
    cand[1]  = pre_p.b;
    cand[2]  = mid_c;
    cand[3]  = fin_p.a;
    cand[4]  = fin_p.b;
    cline[0] = line_q;
    cline[1] = line_q;
    cline[2] = line_q;
    cline[3] = line_mid;
    cline[4] = line_mid;
  end

  always_comb begin
    cnt = 2'd0;
    for (int i = 0; i < MAX_RES; i++) slot[i] = '0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand[i].v && cnt != 2'(MAX_RES)) begin
        slot[cnt] = {cand[i].kind, cand[i].kw, cand[i].s, cand[i].e, cline[i],
                     cand[i].err};
        cnt = cnt + 2'd1;
      end
    end
  end

  always_comb begin
    push_o  = accept_i && (cnt != 2'd0);
    entry_o = {cnt, slot[2], slot[1], slot[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      op_q   <= 2'd0;
      pos_q  <= '0;
      ts_q   <= '0;
      line_q <= LB'(1);
      wb_q   <= '0;
      wl_q   <= '0;
      prev_q <= '0;
      ne_q   <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      op_q   <= op_d;
      pos_q  <= pos_d;
      ts_q   <= ts_d;
      line_q <= line_d;
      wb_q   <= wb_d;
      wl_q   <= wl_d;
      prev_q <= prev_d;
      ne_q   <= ne_d;
    end
  end

  `SSTOK_ASSERT(a_line_nonzero, line_q != '0, "line counter reached zero")
  `SSTOK_ASSERT_IMP(a_eos_restart, $past(accept_i && eos_i), pos_q == '0 && mode_q == MODE_IDLE,
                    "scanner did not restart after end of source")

endmodule
`default_nettype wire

// ----- sv/sstok_fifo.sv -----
// Short queue of result batches between the scanner front end and the result back end.
`default_nettype none
module sstok_fifo import sstok_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output fifo_stat_t            stat_o,
  output logic [WIDTH-1:0]      head_o
);
  `include "assert_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wp_q, rp_q;

  always_comb begin
    stat_o.empty = (wp_q == rp_q);
    stat_o.full  = (wp_q[AW] != rp_q[AW]) && (wp_q[AW-1:0] == rp_q[AW-1:0]);
    head_o       = mem[rp_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !stat_o.full) mem[wp_q[AW-1:0]] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (push_i && !stat_o.full) wp_q <= wp_q + (AW+1)'(1);
      if (pop_i && !stat_o.empty) rp_q <= rp_q + (AW+1)'(1);
    end
  end

  `SSTOK_ASSERT(a_fill_bound, (AW+1)'(wp_q - rp_q) <= (AW+1)'(DEPTH),
                "batch queue holds more than its depth")

endmodule
`default_nettype wire

// ----- sv/sstok_back.sv -----
// Result back end: hands out the results of the head batch one request at a time.
`default_nettype none
module sstok_back import sstok_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire fifo_stat_t stat_i,
  input  wire logic [CNT_W+MAX_RES*(RES_FIX_W+2*OFFSET_BITS+LINE_BITS)-1:0] head_i,
  input  wire logic       pop_i,
  output logic            fifo_pop_o,
  output logic            empty_o,
  output logic [4:0]      token_kind_o,
  output logic [4:0]      keyword_index_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [OFFSET_BITS-1:0] end_offset_o,
  output logic [LINE_BITS-1:0]   line_number_o,
  output logic [1:0]      error_code_o,
  output logic            last_of_run_o
);
  `include "assert_macros.svh"

  localparam int OB      = OFFSET_BITS;
  localparam int LB      = LINE_BITS;
  localparam int RES_W   = RES_FIX_W + 2 * OB + LB;
  localparam int ENTRY_W = CNT_W + MAX_RES * RES_W;

  logic [1:0]       idx_q, idx_d;
  logic [1:0]       cnt;
  logic [RES_W-1:0] sel;
  logic             last;

  always_comb begin
    cnt = head_i[ENTRY_W-1 -: CNT_W];
    sel = head_i[RES_W-1:0];
    for (int i = 1; i < MAX_RES; i++) begin
      if (idx_q == 2'(i)) sel = head_i[i*RES_W +: RES_W];
    end
    last            = (idx_q == cnt - 2'd1);
    empty_o         = stat_i.empty;
    token_kind_o    = sel[RES_W-1 -: 5];
    keyword_index_o = sel[RES_W-6 -: 5];
    start_offset_o  = sel[RES_W-11 -: OB];
    end_offset_o    = sel[RES_W-11-OB -: OB];
    line_number_o   = sel[LB+1:2];
    error_code_o    = sel[1:0];
    last_of_run_o   = last;
    fifo_pop_o      = pop_i && !stat_i.empty && last;
    idx_d           = idx_q;
    if (pop_i && !stat_i.empty) idx_d = last ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 2'd0;
    else         idx_q <= idx_d;
  end

  `SSTOK_ASSERT_IMP(a_batch_nonempty, !stat_i.empty, cnt != 2'd0,
                    "queued batch holds no result")
  `SSTOK_ASSERT_IMP(a_idx_in_batch, !stat_i.empty, idx_q < cnt,
                    "result index runs past the head batch")
  `SSTOK_ASSERT_IMP(a_idx_idle, stat_i.empty, idx_q == 2'd0,
                    "result index left mid-batch with nothing queued")

endmodule
`default_nettype wire

// ----- sv/script_source_tokenizer_unit.sv -----
// Top level of the streaming source tokenizer: scanner, batch queue and result port.
//
//  Channel   Direction  Handshake            Payload
//  ------    ---------  -------------------  ------------------------------------------
//  source    in         push / full          source_byte_i, end_of_source_i
//  tokens    out        pop / empty          token_kind_o .. last_of_run_o (7 fields)
//
// The scanner takes one source byte per cycle whenever full is low, so a byte
// stream enters at one byte per clock. Each byte yields zero to three results,
// written as one batch into a four-entry queue in the same cycle; bytes that
// yield nothing leave no trace in the queue. The result side hands out one
// result per cycle while empty is low, the oldest first, so a three-result
// batch takes three pops. Reset clears the scanner state (line counter to one)
// and empties the queue. full rises only when the queue holds four unfinished
// batches; a stalled result side never holds back the scanner until then.
`default_nettype none
module script_source_tokenizer_unit import sstok_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [7:0]             source_byte_i,
  input  wire logic                   end_of_source_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [4:0]                  token_kind_o,
  output logic [4:0]                  keyword_index_o,
  output logic [OFFSET_BITS-1:0]      start_offset_o,
  output logic [OFFSET_BITS-1:0]      end_offset_o,
  output logic [LINE_BITS-1:0]        line_number_o,
  output logic [1:0]                  error_code_o,
  output logic                        last_of_run_o
);

  // One batch: a result count and three result slots.
  localparam int ENTRY_W = CNT_W + MAX_RES * (RES_FIX_W + 2 * OFFSET_BITS + LINE_BITS);

  fifo_stat_t         stat;
  logic               accept;
  logic               batch_push;
  logic               batch_pop;
  logic [ENTRY_W-1:0] batch;
  logic [ENTRY_W-1:0] head;

  // A byte request is taken whenever the queue has room for a batch.
  assign accept = push && !stat.full;
  assign full   = stat.full;

  sstok_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (source_byte_i),
    .eos_i   (end_of_source_i),
    .push_o  (batch_push),
    .entry_o (batch)
  );

  sstok_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(batch_push),
    .data_i(batch),
    .pop_i (batch_pop),
    .stat_o(stat),
    .head_o(head)
  );

  // The back end walks the head batch and releases it after its last result.
  sstok_back #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stat_i         (stat),
    .head_i         (head),
    .pop_i          (pop),
    .fifo_pop_o     (batch_pop),
    .empty_o        (empty),
    .token_kind_o   (token_kind_o),
    .keyword_index_o(keyword_index_o),
    .start_offset_o (start_offset_o),
    .end_offset_o   (end_offset_o),
    .line_number_o  (line_number_o),
    .error_code_o   (error_code_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
`default_nettype wire
